// File: sv/number_or_text_line_parser_core_defines.svh
// assertion macros shared by the line parser modules
`ifndef NUMBER_OR_TEXT_LINE_PARSER_CORE_DEFINES_SVH
`define NUMBER_OR_TEXT_LINE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define LNP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define LNP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/lnp_pkg.sv
// types, constants and functions of the number or text line parser
`timescale 1ns / 1ps

package lnp_pkg;

  localparam int LINE_CHARS_DEF = 32;
  localparam int CHAR_W = 8;
  localparam int ACC_W = 31;
  localparam int PLC_W = 6;
  localparam int VAL_W = 48;
  localparam int FRAC_BITS = 16;
  localparam int DIV_W = ACC_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int PLACES_MAX = 14;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [PLC_W-1:0] PLC_SAT = {PLC_W{1'b1}};

  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  // line class, also the line_kind code of a result beat
  typedef enum logic [1:0] {
    MODE_EMPTY  = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_TEXT   = 2'd2
  } line_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NUM,
    ST_EMPTY,
    ST_REPLAY
  } fsm_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // powers of ten up to the last place count that still adds a fraction
  function automatic logic [DIV_W-1:0] pow10(input logic [PLC_W-1:0] places);
    logic [DIV_W-1:0] p;
    case (places)
      6'd0:    p = 47'd1;
      6'd1:    p = 47'd10;
      6'd2:    p = 47'd100;
      6'd3:    p = 47'd1000;
      6'd4:    p = 47'd10000;
      6'd5:    p = 47'd100000;
      6'd6:    p = 47'd1000000;
      6'd7:    p = 47'd10000000;
      6'd8:    p = 47'd100000000;
      6'd9:    p = 47'd1000000000;
      6'd10:   p = 47'd10000000000;
      6'd11:   p = 47'd100000000000;
      6'd12:   p = 47'd1000000000000;
      6'd13:   p = 47'd10000000000000;
      6'd14:   p = 47'd100000000000000;
      default: p = 47'd1;
    endcase
    return p;
  endfunction

endpackage

// File: sv/lnp_if.sv
// valid/ready channels for received characters and line results
`timescale 1ns / 1ps

interface lnp_char_if;
  logic                        valid;
  logic                        ready;
  logic [lnp_pkg::CHAR_W-1:0]  char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface lnp_res_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        line_kind;
  logic [lnp_pkg::CHAR_W-1:0]        text_char;
  logic                              is_last;
  logic                              minus_flag;
  logic [lnp_pkg::ACC_W-1:0]         integer_part;
  logic [lnp_pkg::ACC_W-1:0]         fraction_digits;
  logic [lnp_pkg::PLC_W-1:0]         fraction_places;
  logic signed [lnp_pkg::VAL_W-1:0]  value_q16;

  modport source (
    output valid, output line_kind, output text_char, output is_last,
    output minus_flag, output integer_part, output fraction_digits,
    output fraction_places, output value_q16, input ready
  );
  modport sink (
    input valid, input line_kind, input text_char, input is_last,
    input minus_flag, input integer_part, input fraction_digits,
    input fraction_places, input value_q16, output ready
  );
endinterface

// File: sv/lnp_line_mem.sv
// line character store, one write and one registered read port
`timescale 1ns / 1ps

module lnp_line_mem #(
  parameter int DEPTH = lnp_pkg::LINE_CHARS_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [lnp_pkg::CHAR_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [lnp_pkg::CHAR_W-1:0] rdata_o
);

  logic [lnp_pkg::CHAR_W-1:0] mem_q [DEPTH];
  logic [lnp_pkg::CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/lnp_q16_div.sv
// restoring divider for the fraction term, one quotient bit per cycle
`timescale 1ns / 1ps

`include "number_or_text_line_parser_core_defines.svh"

module lnp_q16_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lnp_pkg::DIV_W-1:0]     dividend_i,
  input  logic [lnp_pkg::DIV_W-1:0]     divisor_i,
  output lnp_pkg::div_stat_t            stat_o,
  output logic [lnp_pkg::DIV_W-1:0]     quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [lnp_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [lnp_pkg::DIV_W-1:0]        dvd_q, dvd_d;
  logic [lnp_pkg::DIV_W-1:0]        dvs_q, dvs_d;
  logic [lnp_pkg::DIV_W-1:0]        quo_q, quo_d;
  logic [lnp_pkg::DIV_W-1:0]        rem_q, rem_d;
  logic [lnp_pkg::DIV_W:0]          rem_sh;
  logic                             ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    rem_sh = {rem_q, dvd_q[lnp_pkg::DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = lnp_pkg::DIV_CNT_W'(lnp_pkg::DIV_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? lnp_pkg::DIV_W'(rem_sh - {1'b0, dvs_q})
                 : rem_sh[lnp_pkg::DIV_W-1:0];
      quo_d = {quo_q[lnp_pkg::DIV_W-2:0], ge};
      dvd_d = {dvd_q[lnp_pkg::DIV_W-2:0], 1'b0};
      cnt_d = cnt_q - lnp_pkg::DIV_CNT_W'(1);
      if (cnt_q == lnp_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  `LNP_ASSERT_IMP(a_no_restart, start_i, !busy_q, "divider started while busy")
  `LNP_ASSERT_IMP(a_busy_counts, busy_q, cnt_q != '0, "divider busy with zero count")
  `LNP_ASSERT_NXT(a_done_ends, busy_q && cnt_q == lnp_pkg::DIV_CNT_W'(1) && !start_i,
                  done_q && !busy_q, "divider did not finish on last step")

endmodule

// File: sv/number_or_text_line_parser_core.sv
// number or text line parser, top level
//
//   channel  dir  beat content
//   char_i   in   one received character
//   res_o    out  empty-line, number or stored text character result
//
// a character that does not end a line is taken in ST_IDLE and stored while the store has room
// line end: an empty line goes through ST_EMPTY, text replays each stored character,
// a number waits on the 47-step fraction divider
// characters are refused while a line end is being worked off
// rst_ni clears line state; the character store holds no reset value
// res_o register lets the next character in while a result waits
`timescale 1ns / 1ps

`include "number_or_text_line_parser_core_defines.svh"

module number_or_text_line_parser_core #(
  parameter int LINE_CHARS = lnp_pkg::LINE_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lnp_char_if.sink       char_i,
  lnp_res_if.source      res_o
);

  localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int ACC_W = lnp_pkg::ACC_W;
  localparam int PLC_W = lnp_pkg::PLC_W;
  localparam int CHAR_W = lnp_pkg::CHAR_W;
  localparam int DIV_W = lnp_pkg::DIV_W;
  localparam int VAL_W = lnp_pkg::VAL_W;

  lnp_pkg::fsm_state_e state_q, state_d;
  lnp_pkg::line_mode_e mode_q, mode_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [ACC_W-1:0]   int_q, int_d;
  logic [ACC_W-1:0]   frac_q, frac_d;
  logic [PLC_W-1:0]   plc_q, plc_d;
  logic               point_q, point_d;
  logic               minus_q, minus_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic               data_ok_q, data_ok_d;
  logic [VAL_W-1:0]   mag_q, mag_d;

  logic                out_vld_q, out_vld_d;
  lnp_pkg::line_mode_e out_kind_q, out_kind_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic                out_last_q, out_last_d;
  logic                out_neg_q, out_neg_d;
  logic [ACC_W-1:0]    out_int_q, out_int_d;
  logic [ACC_W-1:0]    out_frac_q, out_frac_d;
  logic [PLC_W-1:0]    out_plc_q, out_plc_d;
  logic [VAL_W-1:0]    out_val_q, out_val_d;

  logic               in_ready, in_fire, is_eol, is_dig;
  logic [CHAR_W-1:0]  c;
  logic [3:0]         dig;
  logic [ACC_W+3:0]   int_x10, frac_x10;
  logic               int_ovf, frac_ovf;
  logic               out_free, out_load, can_load, clr;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [CHAR_W-1:0]  mem_rdata;

  lnp_pkg::div_stat_t div_stat;
  logic               div_start;
  logic [DIV_W-1:0]   div_dvd, div_dvs, div_quo;

  assign c       = char_i.char_code;
  assign in_fire = char_i.valid && in_ready;
  assign is_eol  = (c == lnp_pkg::CHAR_CR) || (c == lnp_pkg::CHAR_LF);
  assign is_dig  = (c >= lnp_pkg::CHAR_ZERO) && (c <= lnp_pkg::CHAR_NINE);
  assign dig     = 4'(c - lnp_pkg::CHAR_ZERO);

  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
  assign int_x10  = {1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0} + {31'd0, dig};
  assign frac_x10 = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0} + {31'd0, dig};
  assign int_ovf  = int_x10 > {4'd0, lnp_pkg::ACC_MAX};
  assign frac_ovf = frac_x10 > {4'd0, lnp_pkg::ACC_MAX};

  assign out_free = !out_vld_q || res_o.ready;
  assign can_load = data_ok_q && out_free;

  assign div_dvd = (plc_q > PLC_W'(lnp_pkg::PLACES_MAX)) ? '0 : {frac_q, 16'd0};
  assign div_dvs = lnp_pkg::pow10(plc_q);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    int_d      = int_q;
    frac_d     = frac_q;
    plc_d      = plc_q;
    point_d    = point_q;
    minus_d    = minus_q;
    rd_idx_d   = rd_idx_q;
    data_ok_d  = data_ok_q;
    mag_d      = mag_q;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = rd_idx_q[AW-1:0];
    div_start  = 1'b0;
    clr        = 1'b0;
    out_load   = 1'b0;
    out_kind_d = lnp_pkg::MODE_EMPTY;
    out_char_d = '0;
    out_last_d = 1'b1;
    out_neg_d  = 1'b0;
    out_int_d  = '0;
    out_frac_d = '0;
    out_plc_d  = '0;
    out_val_d  = '0;

    unique case (state_q)
      lnp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && !is_eol) begin
          if (cnt_q < CW'(LINE_CHARS)) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CW'(1);
          end
          unique case (mode_q)
            lnp_pkg::MODE_NUMBER: begin
              if (is_dig) begin
                if (!point_q) begin
                  if (int_ovf) begin
                    mode_d = lnp_pkg::MODE_TEXT;
                  end else begin
                    int_d = int_x10[ACC_W-1:0];
                  end
                end else begin
                  if (frac_ovf) begin
                    mode_d = lnp_pkg::MODE_TEXT;
                  end else begin
                    frac_d = frac_x10[ACC_W-1:0];
                  end
                  if (plc_q != lnp_pkg::PLC_SAT) begin
                    plc_d = plc_q + PLC_W'(1);
                  end
                end
              end else if (c == lnp_pkg::CHAR_POINT && !point_q) begin
                point_d = 1'b1;
              end else begin
                mode_d = lnp_pkg::MODE_TEXT;
              end
            end
            lnp_pkg::MODE_EMPTY: begin
              if (is_dig) begin
                mode_d = lnp_pkg::MODE_NUMBER;
                int_d  = {27'd0, dig};
              end else if (c == lnp_pkg::CHAR_MINUS) begin
                mode_d  = lnp_pkg::MODE_NUMBER;
                minus_d = 1'b1;
              end else begin
                mode_d = lnp_pkg::MODE_TEXT;
              end
            end
            default: begin
            end
          endcase
        end else if (in_fire) begin
          unique case (mode_q)
            lnp_pkg::MODE_NUMBER: begin
              div_start = 1'b1;
              state_d   = lnp_pkg::ST_DIV;
            end
            lnp_pkg::MODE_TEXT: begin
              rd_idx_d  = '0;
              data_ok_d = 1'b0;
              state_d   = lnp_pkg::ST_REPLAY;
            end
            default: begin
              state_d = lnp_pkg::ST_EMPTY;
            end
          endcase
        end
      end
      lnp_pkg::ST_DIV: begin
        if (div_stat.done) begin
          mag_d   = {1'b0, int_q, 16'd0} + {1'b0, div_quo};
          state_d = lnp_pkg::ST_NUM;
        end
      end
      lnp_pkg::ST_NUM: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = lnp_pkg::MODE_NUMBER;
          out_neg_d  = minus_q;
          out_int_d  = int_q;
          out_frac_d = frac_q;
          out_plc_d  = plc_q;
          out_val_d  = minus_q ? (VAL_W'(0) - mag_q) : mag_q;
          clr        = 1'b1;
          state_d    = lnp_pkg::ST_IDLE;
        end
      end
      lnp_pkg::ST_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          clr      = 1'b1;
          state_d  = lnp_pkg::ST_IDLE;
        end
      end
      lnp_pkg::ST_REPLAY: begin
        // read data of entry rd_idx_q - 1 waits in the store while data_ok_q
        if (can_load) begin
          out_load   = 1'b1;
          out_kind_d = lnp_pkg::MODE_TEXT;
          out_char_d = mem_rdata;
          out_last_d = (rd_idx_q == cnt_q);
          data_ok_d  = 1'b0;
        end
        if ((rd_idx_q < cnt_q) && (!data_ok_q || can_load)) begin
          mem_re    = 1'b1;
          rd_idx_d  = rd_idx_q + CW'(1);
          data_ok_d = 1'b1;
        end
        if (can_load && (rd_idx_q == cnt_q)) begin
          clr     = 1'b1;
          state_d = lnp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lnp_pkg::ST_IDLE;
      end
    endcase

    if (clr) begin
      mode_d  = lnp_pkg::MODE_EMPTY;
      cnt_d   = '0;
      int_d   = '0;
      frac_d  = '0;
      plc_d   = '0;
      point_d = 1'b0;
      minus_d = 1'b0;
    end

    out_vld_d = out_load ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lnp_pkg::ST_IDLE;
      mode_q    <= lnp_pkg::MODE_EMPTY;
      cnt_q     <= '0;
      int_q     <= '0;
      frac_q    <= '0;
      plc_q     <= '0;
      point_q   <= 1'b0;
      minus_q   <= 1'b0;
      rd_idx_q  <= '0;
      data_ok_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      cnt_q     <= cnt_d;
      int_q     <= int_d;
      frac_q    <= frac_d;
      plc_q     <= plc_d;
      point_q   <= point_d;
      minus_q   <= minus_d;
      rd_idx_q  <= rd_idx_d;
      data_ok_q <= data_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
      out_neg_q  <= out_neg_d;
      out_int_q  <= out_int_d;
      out_frac_q <= out_frac_d;
      out_plc_q  <= out_plc_d;
      out_val_q  <= out_val_d;
    end
  end

  lnp_line_mem #(
    .DEPTH (LINE_CHARS),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (c),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lnp_q16_div u_q16_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign char_i.ready          = in_ready;
  assign res_o.valid           = out_vld_q;
  assign res_o.line_kind       = out_kind_q;
  assign res_o.text_char       = out_char_q;
  assign res_o.is_last         = out_last_q;
  assign res_o.minus_flag      = out_neg_q;
  assign res_o.integer_part    = out_int_q;
  assign res_o.fraction_digits = out_frac_q;
  assign res_o.fraction_places = out_plc_q;
  assign res_o.value_q16       = $signed(out_val_q);

  `LNP_ASSERT_IMP(a_done_in_div, div_stat.done, state_q == lnp_pkg::ST_DIV,
                  "divider result outside number line end")
  `LNP_ASSERT_IMP(a_replay_nonempty, state_q == lnp_pkg::ST_REPLAY, cnt_q != '0,
                  "text replay with no stored characters")
  `LNP_ASSERT_NXT(a_last_clears, out_load && out_last_d,
                  state_q == lnp_pkg::ST_IDLE && mode_q == lnp_pkg::MODE_EMPTY && cnt_q == '0,
                  "line state not cleared after final beat")

endmodule
